[hdl/pfrs_pkg.sv]
package pfrs_pkg;

    // Table geometry
    localparam int MAX_OBSTACLES = 64;
    localparam int IDX_W = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
    localparam int CNT_W = $clog2(MAX_OBSTACLES + 1);

    // Field widths
    localparam int COORD_W   = 32;
    localparam int CFG_W     = 31;
    localparam int COUNT_W   = 7;
    localparam int FORCE_W   = 48;
    localparam int ENTRY_W   = 6;
    localparam int REG_IDX_W = 2;

    // Serial arithmetic unit widths and step counts
    localparam int W_W        = 111;
    localparam int A_W        = 64;
    localparam int R_W        = 34;
    localparam int ROOT_W     = 32;
    localparam int STEP_W     = 7;
    localparam int MUL_STEPS  = 31;
    localparam int DIV_STEPS  = 111;
    localparam int SQRT_STEPS = 32;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_GAIN   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_RADIUS = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_COUNT  = 2'd2;

    // Request opcodes
    localparam logic OPC_WRITE = 1'b0;
    localparam logic OPC_EVAL  = 1'b1;

    // Register reset values
    localparam logic [CFG_W-1:0]   GAIN_RESET   = 31'd327680;
    localparam logic [CFG_W-1:0]   RADIUS_RESET = 31'd19661;
    localparam logic [COUNT_W-1:0] COUNT_RESET  = 7'd36;

    typedef enum logic [1:0] {
        ARITH_MUL  = 2'd0,
        ARITH_DIV  = 2'd1,
        ARITH_SQRT = 2'd2
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } arith_stat_t;

endpackage

[hdl/potential_field_repulsion_sum.sv]
// Repulsive potential-field force summation. A write request (opcode 0)
// stores one obstacle point (coord_x, coord_y, signed Q16.16) in table slot
// entry_index. An evaluate request (opcode 1) gives a base position and
// returns one result: the saturating Q32.16 sum over the first
// obstacle_count entries of eta*(1/d - 1/d0)*(p - obs)/d^3, for every
// obstacle at Euclidean distance 0 < d <= d0, plus a flag that is set when a
// term or the sum clamps, or when an obstacle sits exactly on p. Read only
// entries that were written. All arithmetic runs in one shared bit-serial
// unit (multiply 31 steps, square root 32 steps, divide 111 steps). An
// evaluate first squares d0 and takes its reciprocal, then skips obstacles
// outside the box of radius d0 with no arithmetic and those outside the
// circle after squaring; each one in range takes seven divisions. One
// request is in work at a time; a result waits in the output register while
// the next request is taken. The user must see that configuration registers
// are written only while no evaluate is in progress; the block itself does
// not enforce this.
module potential_field_repulsion_sum (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               opcode,
    input  logic [pfrs_pkg::ENTRY_W-1:0]       entry_index,
    input  logic signed [pfrs_pkg::COORD_W-1:0] coord_x,
    input  logic signed [pfrs_pkg::COORD_W-1:0] coord_y,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [pfrs_pkg::FORCE_W-1:0] force_x,
    output logic signed [pfrs_pkg::FORCE_W-1:0] force_y,
    output logic                               overflow_flag,
    input  logic                               cfg_we,
    input  logic [pfrs_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [pfrs_pkg::CFG_W-1:0]         cfg_data
);
    import pfrs_pkg::*;

    typedef enum logic [13:0] {
        ST_IDLE  = 14'h0001,
        ST_D0SQ  = 14'h0002,
        ST_D0RCP = 14'h0004,
        ST_READ  = 14'h0008,
        ST_DIFF  = 14'h0010,
        ST_SQX   = 14'h0020,
        ST_SQY   = 14'h0040,
        ST_SQRT  = 14'h0080,
        ST_RCP   = 14'h0100,
        ST_GAIN  = 14'h0200,
        ST_MUL   = 14'h0400,
        ST_DIV   = 14'h0800,
        ST_ACC   = 14'h1000,
        ST_DONE  = 14'h2000
    } state_t;

    localparam int SQ_W   = 2 * CFG_W;
    localparam int RCP_W  = 49;
    localparam int AXIS_W = COORD_W + 1;
    localparam int TERM_W = FORCE_W + 1;
    localparam int SUM_W  = FORCE_W + 2;

    localparam logic [W_W-1:0]     RCP_NUM = W_W'(1) << 48;
    localparam logic [FORCE_W-1:0] CAP_POS = {1'b0, {(FORCE_W-1){1'b1}}};
    localparam logic [FORCE_W-1:0] CAP_NEG = {1'b1, {(FORCE_W-1){1'b0}}};
    localparam logic signed [SUM_W-1:0] SUM_MAX = {3'b000, {(FORCE_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {3'b111, {(FORCE_W-1){1'b0}}};

    // Configuration
    logic [CFG_W-1:0]   eta_reg, eta_next;
    logic [CFG_W-1:0]   d0_reg, d0_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    // Sequencer and per-request state
    state_t             state_reg, state_next;
    logic               launched_reg, launched_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic               axis_reg, axis_next;
    logic [1:0]         pass_reg, pass_next;
    logic               flag_reg, flag_next;

    // Datapath
    logic [COORD_W-1:0] px_reg, px_next;
    logic [COORD_W-1:0] py_reg, py_next;
    logic [CFG_W-1:0]   ax_reg, ax_next;
    logic [CFG_W-1:0]   ay_reg, ay_next;
    logic               sx_reg, sx_next;
    logic               sy_reg, sy_next;
    logic [SQ_W-1:0]    d0sq_reg, d0sq_next;
    logic [RCP_W-1:0]   rd0_reg, rd0_next;
    logic [SQ_W:0]      s_reg, s_next;
    logic [CFG_W-1:0]   d_reg, d_next;
    logic [A_W-1:0]     k_reg, k_next;
    logic [FORCE_W-1:0] fx_reg, fx_next;
    logic [FORCE_W-1:0] fy_reg, fy_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic [FORCE_W-1:0] force_x_reg, force_x_next;
    logic [FORCE_W-1:0] force_y_reg, force_y_next;
    logic               oflag_reg, oflag_next;

    // Table and serial unit
    logic               in_accept;
    logic               tbl_we;
    logic [IDX_W-1:0]   tbl_waddr;
    logic [IDX_W-1:0]   tbl_raddr;
    logic [COORD_W-1:0] x_rd;
    logic [COORD_W-1:0] y_rd;
    arith_cmd_t         cmd;
    arith_stat_t        stat;
    logic [W_W-1:0]     arg_w;
    logic [A_W-1:0]     arg_a;
    logic [W_W-1:0]     res_w;
    logic [ROOT_W-1:0]  res_root;

    // Combinational helpers
    logic [AXIS_W-1:0]  dx;
    logic [AXIS_W-1:0]  dy;
    logic [AXIS_W-1:0]  adx;
    logic [AXIS_W-1:0]  ady;
    logic [SQ_W:0]      s_sum;
    logic               t_sign;
    logic [FORCE_W-1:0] t_cap;
    logic               t_over;
    logic [FORCE_W-1:0] t_mag;
    logic [TERM_W-1:0]  t_term;
    logic [FORCE_W-1:0] acc_cur;
    logic signed [SUM_W-1:0] acc_sum;
    logic [FORCE_W-1:0] acc_sat;
    logic               acc_clamp;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;

    // Obstacle table: written by write requests, swept during evaluate
    assign tbl_we    = in_accept && (opcode == OPC_WRITE)
                       && (int'(entry_index) < MAX_OBSTACLES);
    assign tbl_waddr = IDX_W'(entry_index);
    assign tbl_raddr = idx_reg[IDX_W-1:0];

    pfrs_ram #(
        .WIDTH (COORD_W),
        .DEPTH (MAX_OBSTACLES)
    ) u_x_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (coord_x),
        .raddr (tbl_raddr),
        .rdata (x_rd)
    );

    pfrs_ram #(
        .WIDTH (COORD_W),
        .DEPTH (MAX_OBSTACLES)
    ) u_y_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (coord_y),
        .raddr (tbl_raddr),
        .rdata (y_rd)
    );

    pfrs_arith u_arith (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .arg_w    (arg_w),
        .arg_a    (arg_a),
        .stat     (stat),
        .res_w    (res_w),
        .res_root (res_root)
    );

    // Offsets from the obstacle to the base point, and their magnitudes
    assign dx  = {px_reg[COORD_W-1], px_reg} - {x_rd[COORD_W-1], x_rd};
    assign dy  = {py_reg[COORD_W-1], py_reg} - {y_rd[COORD_W-1], y_rd};
    assign adx = dx[AXIS_W-1] ? (AXIS_W'(0) - dx) : dx;
    assign ady = dy[AXIS_W-1] ? (AXIS_W'(0) - dy) : dy;

    // Squared distance: ay^2 arrives from the unit, ax^2 waits in s_reg
    assign s_sum = s_reg + {1'b0, res_w[SQ_W-1:0]};

    // Term for the current axis: clamp the quotient, apply sign, add
    assign t_sign  = axis_reg ? sy_reg : sx_reg;
    assign t_cap   = t_sign ? CAP_NEG : CAP_POS;
    assign t_over  = (|res_w[W_W-1:FORCE_W]) || (res_w[FORCE_W-1:0] > t_cap);
    assign t_mag   = t_over ? t_cap : res_w[FORCE_W-1:0];
    assign t_term  = t_sign ? (TERM_W'(0) - {1'b0, t_mag}) : {1'b0, t_mag};
    assign acc_cur = axis_reg ? fy_reg : fx_reg;
    assign acc_sum = $signed({{2{acc_cur[FORCE_W-1]}}, acc_cur})
                   + $signed({t_term[TERM_W-1], t_term});

    always_comb
    begin
        acc_clamp = 1'b0;
        acc_sat   = acc_sum[FORCE_W-1:0];
        if (acc_sum > SUM_MAX)
        begin
            acc_clamp = 1'b1;
            acc_sat   = CAP_POS;
        end
        else if (acc_sum < SUM_MIN)
        begin
            acc_clamp = 1'b1;
            acc_sat   = CAP_NEG;
        end
    end

    // Configuration writes
    always_comb
    begin
        eta_next   = eta_reg;
        d0_next    = d0_reg;
        count_next = count_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_GAIN:   eta_next   = cfg_data;
                REG_RADIUS: d0_next    = cfg_data;
                REG_COUNT:  count_next = cfg_data[COUNT_W-1:0];
                default:    eta_next   = eta_reg;
            endcase
        end
    end

    // Sequencer: every arithmetic state launches the unit, then waits for
    // its done pulse and takes the result, once per pass in the divide state
    always_comb
    begin
        state_next     = state_reg;
        launched_next  = launched_reg;
        idx_next       = idx_reg;
        n_next         = n_reg;
        axis_next      = axis_reg;
        pass_next      = pass_reg;
        flag_next      = flag_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        d0sq_next      = d0sq_reg;
        rd0_next       = rd0_reg;
        s_next         = s_reg;
        d_next         = d_reg;
        k_next         = k_reg;
        fx_next        = fx_reg;
        fy_next        = fy_reg;
        out_valid_next = out_valid_reg && !out_ready;
        force_x_next   = force_x_reg;
        force_y_next   = force_y_reg;
        oflag_next     = oflag_reg;
        cmd.start      = 1'b0;
        cmd.op         = ARITH_MUL;
        arg_w          = '0;
        arg_a          = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (opcode == OPC_EVAL))
                begin
                    px_next  = coord_x;
                    py_next  = coord_y;
                    idx_next = '0;
                    if (int'(count_reg) > MAX_OBSTACLES)
                    begin
                        n_next = CNT_W'(MAX_OBSTACLES);
                    end
                    else
                    begin
                        n_next = CNT_W'(count_reg);
                    end
                    fx_next    = '0;
                    fy_next    = '0;
                    flag_next  = 1'b0;
                    state_next = ST_D0SQ;
                end
            end

            ST_D0SQ:
            begin
                cmd.op = ARITH_MUL;
                arg_w  = W_W'(d0_reg);
                arg_a  = A_W'(d0_reg);
                if (!launched_reg)
                begin
                    cmd.start     = 1'b1;
                    launched_next = 1'b1;
                end
                else if (stat.done)
                begin
                    launched_next = 1'b0;
                    d0sq_next     = res_w[SQ_W-1:0];
                    state_next    = ST_D0RCP;
                end
            end

            ST_D0RCP:
            begin
                cmd.op = ARITH_DIV;
                arg_w  = RCP_NUM;
                arg_a  = A_W'(d0_reg);
                if (!launched_reg)
                begin
                    cmd.start     = 1'b1;
                    launched_next = 1'b1;
                end
                else if (stat.done)
                begin
                    launched_next = 1'b0;
                    rd0_next      = res_w[RCP_W-1:0];
                    state_next    = ST_READ;
                end
            end

            ST_READ:
            begin
                // Table address settles here; data is valid next cycle
                if (idx_reg >= n_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_DIFF;
                end
            end

            ST_DIFF:
            begin
                ax_next = adx[CFG_W-1:0];
                ay_next = ady[CFG_W-1:0];
                sx_next = dx[AXIS_W-1];
                sy_next = dy[AXIS_W-1];
                if ((adx == '0) && (ady == '0))
                begin
                    // Obstacle on the base point: skip, flag
                    flag_next  = 1'b1;
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_READ;
                end
                else if ((adx > AXIS_W'(d0_reg)) || (ady > AXIS_W'(d0_reg)))
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_SQX;
                end
            end

            ST_SQX:
            begin
                cmd.op = ARITH_MUL;
                arg_w  = W_W'(ax_reg);
                arg_a  = A_W'(ax_reg);
                if (!launched_reg)
                begin
                    cmd.start     = 1'b1;
                    launched_next = 1'b1;
                end
                else if (stat.done)
                begin
                    launched_next = 1'b0;
                    s_next        = {1'b0, res_w[SQ_W-1:0]};
                    state_next    = ST_SQY;
                end
            end

            ST_SQY:
            begin
                cmd.op = ARITH_MUL;
                arg_w  = W_W'(ay_reg);
                arg_a  = A_W'(ay_reg);
                if (!launched_reg)
                begin
                    cmd.start     = 1'b1;
                    launched_next = 1'b1;
                end
                else if (stat.done)
                begin
                    launched_next = 1'b0;
                    s_next        = s_sum;
                    if (s_sum > {1'b0, d0sq_reg})
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_SQRT;
                    end
                end
            end

            ST_SQRT:
            begin
                cmd.op = ARITH_SQRT;
                arg_w  = W_W'(s_reg);
                arg_a  = '0;
                if (!launched_reg)
                begin
                    cmd.start     = 1'b1;
                    launched_next = 1'b1;
                end
                else if (stat.done)
                begin
                    launched_next = 1'b0;
                    d_next        = res_root[CFG_W-1:0];
                    state_next    = ST_RCP;
                end
            end

            ST_RCP:
            begin
                cmd.op = ARITH_DIV;
                arg_w  = RCP_NUM;
                arg_a  = A_W'(d_reg);
                if (!launched_reg)
                begin
                    cmd.start     = 1'b1;
                    launched_next = 1'b1;
                end
                else if (stat.done)
                begin
                    launched_next = 1'b0;
                    state_next    = ST_GAIN;
                end
            end

            ST_GAIN:
            begin
                // 1/d - 1/d0 in Q.32, taken from the held quotient
                cmd.op = ARITH_MUL;
                arg_w  = W_W'(eta_reg);
                arg_a  = A_W'(res_w[RCP_W-1:0] - rd0_reg);
                if (!launched_reg)
                begin
                    cmd.start     = 1'b1;
                    launched_next = 1'b1;
                end
                else if (stat.done)
                begin
                    launched_next = 1'b0;
                    k_next        = res_w[A_W+15:16];
                    axis_next     = 1'b0;
                    state_next    = ST_MUL;
                end
            end

            ST_MUL:
            begin
                cmd.op = ARITH_MUL;
                arg_w  = W_W'(axis_reg ? ay_reg : ax_reg);
                arg_a  = k_reg;
                if (!launched_reg)
                begin
                    cmd.start     = 1'b1;
                    launched_next = 1'b1;
                end
                else if (stat.done)
                begin
                    launched_next = 1'b0;
                    pass_next     = 2'd0;
                    state_next    = ST_DIV;
                end
            end

            ST_DIV:
            begin
                // Three passes divide k*|delta|*2^16 by d^3
                cmd.op = ARITH_DIV;
                if (pass_reg == 2'd0)
                begin
                    arg_w = {res_w[W_W-17:0], 16'b0};
                end
                else
                begin
                    arg_w = res_w;
                end
                arg_a = A_W'(d_reg);
                if (!launched_reg)
                begin
                    cmd.start     = 1'b1;
                    launched_next = 1'b1;
                end
                else if (stat.done)
                begin
                    launched_next = 1'b0;
                    if (pass_reg == 2'd2)
                    begin
                        pass_next  = 2'd0;
                        state_next = ST_ACC;
                    end
                    else
                    begin
                        pass_next = pass_reg + 1'b1;
                    end
                end
            end

            ST_ACC:
            begin
                if (t_over || acc_clamp)
                begin
                    flag_next = 1'b1;
                end
                if (axis_reg)
                begin
                    fy_next    = acc_sat;
                    axis_next  = 1'b0;
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_READ;
                end
                else
                begin
                    fx_next    = acc_sat;
                    axis_next  = 1'b1;
                    state_next = ST_MUL;
                end
            end

            ST_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    force_x_next   = fx_reg;
                    force_y_next   = fy_reg;
                    oflag_next     = flag_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eta_reg       <= GAIN_RESET;
            d0_reg        <= RADIUS_RESET;
            count_reg     <= COUNT_RESET;
            state_reg     <= ST_IDLE;
            launched_reg  <= 1'b0;
            idx_reg       <= '0;
            n_reg         <= '0;
            axis_reg      <= 1'b0;
            pass_reg      <= 2'd0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            eta_reg       <= eta_next;
            d0_reg        <= d0_next;
            count_reg     <= count_next;
            state_reg     <= state_next;
            launched_reg  <= launched_next;
            idx_reg       <= idx_next;
            n_reg         <= n_next;
            axis_reg      <= axis_next;
            pass_reg      <= pass_next;
            flag_reg      <= flag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg      <= px_next;
        py_reg      <= py_next;
        ax_reg      <= ax_next;
        ay_reg      <= ay_next;
        sx_reg      <= sx_next;
        sy_reg      <= sy_next;
        d0sq_reg    <= d0sq_next;
        rd0_reg     <= rd0_next;
        s_reg       <= s_next;
        d_reg       <= d_next;
        k_reg       <= k_next;
        fx_reg      <= fx_next;
        fy_reg      <= fy_next;
        force_x_reg <= force_x_next;
        force_y_reg <= force_y_next;
        oflag_reg   <= oflag_next;
    end

    assign out_valid     = out_valid_reg;
    assign force_x       = force_x_reg;
    assign force_y       = force_y_reg;
    assign overflow_flag = oflag_reg;

`ifndef NO_ASSERTIONS
    // Never launch the serial unit while it is still stepping
    a_no_relaunch: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> !stat.busy)
        else $error("serial unit launched while busy");

    // Every done pulse answers a launch the sequencer is waiting on
    a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> launched_reg)
        else $error("unexpected done from serial unit");

    // The sweep never runs past the entry count
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (idx_reg <= n_reg))
        else $error("obstacle index beyond count");

    // A finished evaluate leaves the unit idle and unclaimed
    a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> (!launched_reg && !stat.busy))
        else $error("evaluate finished with arithmetic pending");
`endif

endmodule

[hdl/pfrs_ram.sv]
module pfrs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/pfrs_arith.sv]
module pfrs_arith (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pfrs_pkg::arith_cmd_t         cmd,
    input  logic [pfrs_pkg::W_W-1:0]     arg_w,
    input  logic [pfrs_pkg::A_W-1:0]     arg_a,
    output pfrs_pkg::arith_stat_t        stat,
    output logic [pfrs_pkg::W_W-1:0]     res_w,
    output logic [pfrs_pkg::ROOT_W-1:0]  res_root
);
    import pfrs_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    arith_op_t         op_reg, op_next;
    logic [W_W-1:0]    w_reg, w_next;
    logic [A_W-1:0]    a_reg, a_next;
    logic [R_W-1:0]    r_reg, r_next;

    logic [A_W:0]      mul_sum;
    logic [CFG_W:0]    div_t;
    logic [CFG_W:0]    div_diff;
    logic              div_ge;
    logic [R_W+1:0]    sq_rem;
    logic [R_W+1:0]    sq_trial;
    logic [R_W+1:0]    sq_diff;
    logic              sq_ge;
    logic [STEP_W-1:0] steps;

    // Shift-add multiply: accumulator above, multiplier bits below
    assign mul_sum = {1'b0, w_reg[A_W+MUL_STEPS-1:MUL_STEPS]}
                   + (w_reg[0] ? {1'b0, a_reg} : '0);

    // Restoring divide: one quotient bit per step
    assign div_t    = {r_reg[CFG_W-1:0], w_reg[W_W-1]};
    assign div_ge   = div_t >= {1'b0, a_reg[CFG_W-1:0]};
    assign div_diff = div_t - {1'b0, a_reg[CFG_W-1:0]};

    // Digit-by-digit square root: one root bit per step
    assign sq_rem   = {r_reg, w_reg[2*ROOT_W-1:2*ROOT_W-2]};
    assign sq_trial = {{(R_W-ROOT_W){1'b0}}, a_reg[ROOT_W-1:0], 2'b01};
    assign sq_ge    = sq_rem >= sq_trial;
    assign sq_diff  = sq_rem - sq_trial;

    always_comb
    begin
        case (cmd.op)
            ARITH_MUL:  steps = STEP_W'(MUL_STEPS);
            ARITH_DIV:  steps = STEP_W'(DIV_STEPS);
            ARITH_SQRT: steps = STEP_W'(SQRT_STEPS);
            default:    steps = STEP_W'(MUL_STEPS);
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        w_next    = w_reg;
        a_next    = a_reg;
        r_next    = r_reg;
        if (cmd.start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = steps;
            op_next   = cmd.op;
            w_next    = arg_w;
            a_next    = arg_a;
            r_next    = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            case (op_reg)
                ARITH_MUL:
                begin
                    w_next = {{(W_W-A_W-MUL_STEPS){1'b0}}, mul_sum,
                              w_reg[MUL_STEPS-1:1]};
                end
                ARITH_DIV:
                begin
                    w_next = {w_reg[W_W-2:0], div_ge};
                    r_next = R_W'(div_ge ? div_diff : div_t);
                end
                ARITH_SQRT:
                begin
                    w_next = {w_reg[W_W-3:0], 2'b00};
                    r_next = sq_ge ? sq_diff[R_W-1:0] : sq_rem[R_W-1:0];
                    a_next = {a_reg[A_W-2:0], sq_ge};
                end
                default:
                begin
                    w_next = w_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= ARITH_MUL;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
        a_reg <= a_next;
        r_reg <= r_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign res_w     = w_reg;
    assign res_root  = a_reg[ROOT_W-1:0];

endmodule

[verif/pfrs_scoreboard.sv]
module pfrs_scoreboard
    import pfrs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic                      opcode,
    input  logic [ENTRY_W-1:0]        entry_index,
    input  logic signed [COORD_W-1:0] coord_x,
    input  logic signed [COORD_W-1:0] coord_y,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic signed [FORCE_W-1:0] force_x,
    input  logic signed [FORCE_W-1:0] force_y,
    input  logic                      overflow_flag,
    input  logic                      cfg_we,
    input  logic [REG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_W-1:0]          cfg_data,
    output int                        fault_count,
    output int                        open_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint FORCE_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint FORCE_MIN = -64'sh0000_8000_0000_0000;

    typedef struct packed {
        logic [FORCE_W-1:0] fx;
        logic [FORCE_W-1:0] fy;
        logic               flag;
    } force_rec_t;

    logic [CFG_W-1:0]   eta;
    logic [CFG_W-1:0]   radius;
    logic [COUNT_W-1:0] count;
    logic [COORD_W-1:0] obs_x [MAX_OBSTACLES];
    logic [COORD_W-1:0] obs_y [MAX_OBSTACLES];
    force_rec_t         force_q [$];

    function automatic logic [63:0] int_sqrt(logic [63:0] s);
        logic [63:0] res;
        logic [63:0] one;
        res = 0;
        one = 64'h1 << 62;
        while (one > s) one = one >> 2;
        while (one != 0)
        begin
            if (s >= res + one)
            begin
                s = s - res - one;
                res = (res >> 1) + one;
            end
            else
                res = res >> 1;
            one = one >> 2;
        end
        return res;
    endfunction

    function automatic longint clamp_force(longint v, inout bit hit);
        if (v > FORCE_MAX)
        begin
            hit = 1'b1;
            return FORCE_MAX;
        end
        if (v < FORCE_MIN)
        begin
            hit = 1'b1;
            return FORCE_MIN;
        end
        return v;
    endfunction

    // One axis of one obstacle's push: k*|delta|*2^16/d^3, clamped to 48 bits
    function automatic longint axis_push(logic [63:0] k, longint delta, logic [63:0] d,
                                         inout bit hit);
        logic [63:0]  mag;
        logic [63:0]  cap;
        logic [127:0] num;
        logic [127:0] quo;
        mag = (delta < 0) ? 64'(-delta) : 64'(delta);
        cap = (delta < 0) ? 64'h0000_8000_0000_0000 : 64'h0000_7FFF_FFFF_FFFF;
        if (mag == 0 || k == 0) return 0;
        num = ({64'd0, k} * {64'd0, mag}) << 16;
        quo = num / ({64'd0, d} * {64'd0, d} * {64'd0, d});
        if (quo > {64'd0, cap})
        begin
            hit = 1'b1;
            quo = {64'd0, cap};
        end
        return (delta < 0) ? -longint'(quo[63:0]) : longint'(quo[63:0]);
    endfunction

    function automatic force_rec_t sum_repulsion(logic signed [31:0] px,
                                                 logic signed [31:0] py);
        force_rec_t   r;
        longint       fx;
        longint       fy;
        longint       dx;
        longint       dy;
        longint       tx;
        longint       ty;
        logic [63:0]  ax;
        logic [63:0]  ay;
        logic [63:0]  d0;
        logic [63:0]  s;
        logic [63:0]  d;
        logic [63:0]  diff;
        logic [127:0] g;
        bit           hit;
        int           n;
        fx = 0;
        fy = 0;
        hit = 1'b0;
        d0 = {33'd0, radius};
        n = (count > MAX_OBSTACLES) ? MAX_OBSTACLES : int'(count);
        for (int i = 0; i < n; i++)
        begin
            dx = longint'(px) - longint'($signed(obs_x[i]));
            dy = longint'(py) - longint'($signed(obs_y[i]));
            ax = (dx < 0) ? 64'(-dx) : 64'(dx);
            ay = (dy < 0) ? 64'(-dy) : 64'(dy);
            if (ax == 0 && ay == 0)
            begin
                hit = 1'b1;
                continue;
            end
            if (ax > d0 || ay > d0) continue;
            s = ax * ax + ay * ay;
            if (s > d0 * d0 || d0 == 0) continue;
            d = int_sqrt(s);
            if (d == 0) d = 1;
            diff = ((64'h1 << 48) / d) - ((64'h1 << 48) / d0);
            g = {64'd0, diff} * {97'd0, eta};
            tx = axis_push(g[79:16], dx, d, hit);
            fx = clamp_force(fx + tx, hit);
            ty = axis_push(g[79:16], dy, d, hit);
            fy = clamp_force(fy + ty, hit);
        end
        r.fx = fx[47:0];
        r.fy = fy[47:0];
        r.flag = hit;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        force_rec_t want;
        if (!rst_n)
        begin
            eta = GAIN_RESET;
            radius = RADIUS_RESET;
            count = COUNT_RESET;
            force_q.delete();
            fault_count = 0;
            open_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_GAIN:   eta = cfg_data;
                    REG_RADIUS: radius = cfg_data;
                    REG_COUNT:  count = cfg_data[COUNT_W-1:0];
                    default:    ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                if (opcode == OPC_WRITE)
                begin
                    obs_x[entry_index] = coord_x;
                    obs_y[entry_index] = coord_y;
                end
                else
                    force_q.push_back(sum_repulsion(coord_x, coord_y));
            end
            if (out_valid && out_ready)
            begin
                if (force_q.size() == 0)
                begin
                    if (fault_count < 10)
                        $display("unexpected force result x=%h y=%h flag=%b",
                                 force_x, force_y, overflow_flag);
                    fault_count++;
                end
                else
                begin
                    want = force_q.pop_front();
                    if (want.fx !== force_x || want.fy !== force_y ||
                        want.flag !== overflow_flag)
                    begin
                        if (fault_count < 10)
                            $display("force mismatch: expected x=%h y=%h flag=%b, got x=%h y=%h flag=%b",
                                     want.fx, want.fy, want.flag,
                                     force_x, force_y, overflow_flag);
                        fault_count++;
                    end
                end
            end
            open_count = force_q.size();
        end
    end

endmodule

[verif/potential_field_repulsion_sum_test.sv]
module potential_field_repulsion_sum_test;
    import pfrs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Unused register slot; writes to it must leave the block unchanged
    localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;
    // Cycles without any handshake before the run is declared hung.
    localparam int STALL_LIMIT = 300000;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic                      opcode;
    logic [ENTRY_W-1:0]        entry_index;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic                      out_valid;
    logic                      out_ready;
    logic signed [FORCE_W-1:0] force_x;
    logic signed [FORCE_W-1:0] force_y;
    logic                      overflow_flag;
    logic                      cfg_we;
    logic [REG_IDX_W-1:0]      cfg_index;
    logic [CFG_W-1:0]          cfg_data;
    int                        fault_count;
    int                        open_count;
    int                        quiet_cycles;
    bit                        calm;

    potential_field_repulsion_sum DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .entry_index(entry_index),
        .coord_x(coord_x), .coord_y(coord_y),
        .out_valid(out_valid), .out_ready(out_ready),
        .force_x(force_x), .force_y(force_y), .overflow_flag(overflow_flag),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    pfrs_scoreboard checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .entry_index(entry_index),
        .coord_x(coord_x), .coord_y(coord_y),
        .out_valid(out_valid), .out_ready(out_ready),
        .force_x(force_x), .force_y(force_y), .overflow_flag(overflow_flag),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fault_count(fault_count), .open_count(open_count)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Hang detection: count cycles in which neither channel moves a request
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side: draw a stall per result, none while calm is set.
    // Always called at a falling edge; out_ready is assigned once per step.
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready)) @(posedge clk);
            @(negedge clk);
        end
    end

    // Issue one request. Entered and left at a falling edge; valid stays up on
    // exit so a back-to-back request does not drop it in the same step.
    task automatic send_request(logic op, logic [ENTRY_W-1:0] idx,
                                logic [31:0] x, logic [31:0] y);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        entry_index <= idx;
        coord_x <= x;
        coord_y <= y;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // Drop valid and hold until every result is back and the block has gone idle
    task automatic drain;
        in_valid <= 1'b0;
        while (open_count != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic program_regs(logic [CFG_W-1:0] gain, logic [CFG_W-1:0] rad,
                                logic [COUNT_W-1:0] cnt);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= REG_GAIN;
        cfg_data <= gain;
        @(negedge clk);
        cfg_index <= REG_RADIUS;
        cfg_data <= rad;
        @(negedge clk);
        cfg_index <= REG_COUNT;
        cfg_data <= CFG_W'(cnt);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Signed offset in [-span, span] around a center, wrapped to 32 bits
    function automatic logic [31:0] near(logic [31:0] center, longint span);
        longint off;
        off = longint'($urandom_range(0, 32'(2 * span))) - span;
        return 32'(longint'($signed(center)) + off);
    endfunction

    initial
    begin
        logic [CFG_W-1:0]   gain;
        logic [CFG_W-1:0]   rad;
        logic [COUNT_W-1:0] cnt;
        logic [31:0]        cx;
        logic [31:0]        cy;
        longint             span;

        rst_n = 1'b0;
        calm = 1'b0;
        in_valid = 1'b0;
        opcode = OPC_WRITE;
        entry_index = '0;
        coord_x = '0;
        coord_y = '0;
        cfg_we = 1'b0;
        cfg_index = REG_GAIN;
        cfg_data = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: extreme coordinates, obstacles on the radius edge, one LSB apart
        send_request(OPC_WRITE, ENTRY_W'(0), 32'h0, 32'h0);
        send_request(OPC_WRITE, ENTRY_W'(1), 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_request(OPC_WRITE, ENTRY_W'(2), 32'h8000_0000, 32'h8000_0000);
        send_request(OPC_WRITE, ENTRY_W'(3), 32'h0000_3000, -32'sh4000);
        send_request(OPC_WRITE, ENTRY_W'(4), -32'sh2000, 32'h0000_1000);
        send_request(OPC_WRITE, ENTRY_W'(5), 32'd19661, 32'h0);
        send_request(OPC_WRITE, ENTRY_W'(6), 32'h0, -32'sd19662);
        send_request(OPC_WRITE, ENTRY_W'(7), 32'h1, 32'h0);
        send_request(OPC_WRITE, ENTRY_W'(63), 32'h7FFF_FFFF, 32'h8000_0000);
        program_regs(GAIN_RESET, RADIUS_RESET, 7'd8);
        send_request(OPC_EVAL, ENTRY_W'(0), 32'h0, 32'h0);
        send_request(OPC_EVAL, ENTRY_W'(0), 32'h100, 32'h100);
        send_request(OPC_EVAL, ENTRY_W'(0), 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_request(OPC_EVAL, ENTRY_W'(0), 32'h8000_0000, 32'h8000_0000);
        send_request(OPC_EVAL, ENTRY_W'(0), 32'h7FFF_FFFF, 32'h8000_0000);
        // The spare register index must change nothing
        drain();
        cfg_we <= 1'b1;
        cfg_index <= REG_SPARE;
        cfg_data <= '1;
        @(negedge clk);
        cfg_we <= 1'b0;
        send_request(OPC_EVAL, ENTRY_W'(0), 32'h100, 32'h100);
        // Largest gain and radius: terms and sums clamp
        program_regs(31'h7FFF_FFFF, 31'h7FFF_FFFF, 7'd8);
        send_request(OPC_EVAL, ENTRY_W'(0), 32'h10, 32'h10);
        send_request(OPC_EVAL, ENTRY_W'(0), 32'h2, 32'h0);
        // Zero gain and zero radius: only a zero distance flags
        program_regs(31'd0, 31'd0, 7'd8);
        send_request(OPC_EVAL, ENTRY_W'(0), 32'h0, 32'h0);
        send_request(OPC_EVAL, ENTRY_W'(0), 32'h5, 32'h5);
        // Smallest radius: an obstacle exactly one LSB away is in range
        program_regs(31'd1, 31'd1, 7'd8);
        send_request(OPC_EVAL, ENTRY_W'(0), 32'h1, 32'h0);

        // Fill the rest of the table so any count is safe to evaluate
        for (int i = 8; i < MAX_OBSTACLES; i++)
            send_request(OPC_WRITE, ENTRY_W'(i), near(32'h0, 32'h30000),
                         near(32'h0, 32'h30000));

        // Random phases: each picks a setting, then mixes table updates near a
        // center with evaluates near the same center
        for (int ph = 0; ph < 8; ph++)
        begin
            gain = CFG_W'($urandom_range(0, 32'h7FFF_FFFF));
            cx = (ph % 2 == 0) ? 32'h0 : $urandom;
            cy = (ph % 2 == 0) ? 32'h0 : $urandom;
            case (ph)
                0: begin gain = GAIN_RESET; rad = RADIUS_RESET; cnt = 7'd8; end
                1: begin gain = 31'h7FFF_FFFF; rad = 31'd1; cnt = 7'd16; end
                2: begin gain = 31'd0; rad = 31'h7FFF_FFFF; cnt = 7'd4; end
                3: begin rad = 31'h10000; cnt = 7'd64; end
                4: begin rad = 31'd0; cnt = 7'd127; end
                5: begin gain = 31'd1; rad = CFG_W'($urandom_range(1, 32'h7FFF_FFFF)); cnt = 7'd3; end
                6: begin rad = 31'h7FFF_FFFF; cnt = 7'd8; end
                default: begin gain = GAIN_RESET; rad = RADIUS_RESET; cnt = 7'd0; end
            endcase
            program_regs(gain, rad, cnt);
            calm = (ph % 3 == 1);
            span = (rad > 31'h3FFF_FFFF) ? 64'h7FFF_FFFF : ((rad < 2) ? 4 : 2 * rad);
            if (ph == 3) span = 64'h40000;
            for (int n = 0; n < 27; n++)
            begin
                // Occasionally hold off until the block has nothing outstanding
                if ($urandom_range(0, 30) == 0)
                begin
                    in_valid <= 1'b0;
                    while (open_count != 0) @(negedge clk);
                end
                if ($urandom_range(0, 9) == 0)
                    send_request(1'($urandom_range(0, 1)), ENTRY_W'($urandom),
                                 $urandom, $urandom);
                else if ($urandom_range(0, 9) < 6)
                    send_request(OPC_WRITE,
                                 ENTRY_W'($urandom_range(0, MAX_OBSTACLES - 1)),
                                 near(cx, span), near(cy, span));
                else
                    send_request(OPC_EVAL, ENTRY_W'(0), near(cx, span / 2),
                                 near(cy, span / 2));
            end
        end
        calm = 1'b0;

        drain();
        if (fault_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
